FILE: sv/dht_pkg.sv
// shared constants, codes and types of the double hash table insert unit
package dht_pkg;

    // configuration register and field widths
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 1;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int OUT_TDATA_W = 24;

    // defaults for the top level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_BITS    = 31;

    // register values after reset
    localparam logic [CFG_W-1:0] RESET_SLOT_LIMIT = 11'd1021;
    localparam logic [CFG_W-1:0] RESET_STEP_PRIME = 11'd1019;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SLOT_LIMIT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_PRIME = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NO_SLOT  = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD_POS,
        S_MOD_STEP,
        S_MOD_STRIDE,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_DONE
    } state_t;

endpackage

FILE: sv/dht_ram.sv
// generic single-write, single-read ram with registered read data
module dht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/dht_mod_unit.sv
// shared bit-serial remainder unit, one dividend bit per cycle
module dht_mod_unit
    import dht_pkg::*;
#(
    parameter int DVD_W = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic             done,
    output logic [CFG_W-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [CFG_W:0]   trial;
    logic [CFG_W-1:0] rem_step;

    // restoring step: shift in next dividend bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_step = CFG_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_step = trial[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !start;
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    // remainder is reduced below the divisor once finished
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

    // a start on an idle unit loads the run counter with the dividend width
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && cnt_reg == '0) |=> (cnt_reg == CNT_W'(DVD_W)))
        else $error("run length not loaded");

    a_no_done_while_running: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > CNT_W'(1)) |=> !done_reg)
        else $error("done raised early");

endmodule

FILE: sv/double_hash_table_insert_unit.sv
// top level: double hashing insert unit with slot store, sequencer and shared remainder unit
// a word that finds the table full skips the remainders and the probes;
//   the remainders run over DVD_W = max(KEY_BITS, 11) dividend bits
// one word at a time: s_tready is high only in idle; the three remainders through the one serial unit dominate
// each probe passes through S_PROBE_RD and S_PROBE_CHK for the registered read of the slot store
// reset: slot limit 1021, step_prime 1019, count zero, then a clearing pass over all
//   TABLE_DEPTH entries of the slot store with s_tready low
module double_hash_table_insert_unit
    import dht_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = DEF_KEY_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [CFG_W-1:0]                    cfg_wdata,
    // input words
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((KEY_BITS+7)/8)*8-1:0]       s_tdata,   // key
    // result words
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_TDATA_W-1:0]              m_tdata    // status, slot, count
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int DVD_W  = (KEY_BITS > CFG_W) ? KEY_BITS : CFG_W;
    localparam int PAD_W  = OUT_TDATA_W - STATUS_W - SLOT_W - COUNT_W;
    localparam int WORD_W = KEY_BITS + 1;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] slot_limit_reg;
    logic [CFG_W-1:0] step_prime_reg;
    logic [CFG_W-1:0] eff_size;
    logic [CFG_W-1:0] eff_prime;

    // per-word working registers
    logic [KEY_BITS-1:0] key_reg;
    logic [CFG_W-1:0]    pos_reg;
    logic [CFG_W-1:0]    stride_reg;
    logic [CFG_W-1:0]    probe_reg;
    status_t             res_status_reg;
    logic [CFG_W-1:0]    res_slot_reg;

    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // shared remainder unit
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [CFG_W-1:0] div_divisor;
    logic             div_done;
    logic [CFG_W-1:0] div_rem;

    // slot store: {key, used}
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              accept;
    logic              table_full;
    logic              slot_free;
    logic              last_probe;
    logic              out_free;
    logic [CFG_W-1:0]  step_val;
    logic [CFG_W:0]    pos_sum;
    logic [CFG_W-1:0]  pos_adv;

    // size zero reads as one, anything above the store depth saturates
    always_comb
    begin
        if (slot_limit_reg == '0)
        begin
            eff_size = CFG_W'(1);
        end
        else if (32'(slot_limit_reg) > TABLE_DEPTH)
        begin
            eff_size = CFG_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = slot_limit_reg;
        end
    end

    assign eff_prime  = (step_prime_reg == '0) ? CFG_W'(1) : step_prime_reg;
    assign accept     = s_tvalid && s_tready;
    assign table_full = 32'(count_reg) >= 32'(eff_size);
    assign slot_free  = !ram_rdata[0];
    assign last_probe = probe_reg == eff_size - CFG_W'(1);
    assign out_free   = !m_tvalid_reg || m_tready;

    // step is prime minus key mod prime, never zero
    assign step_val = eff_prime - div_rem;

    // next probe position as a running sum modulo the size
    assign pos_sum = {1'b0, pos_reg} + {1'b0, stride_reg};
    assign pos_adv = (pos_sum >= {1'b0, eff_size}) ? CFG_W'(pos_sum - {1'b0, eff_size})
                                                   : pos_sum[CFG_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = table_full ? S_DONE : S_MOD_POS;
                end
            end
            S_MOD_POS:
            begin
                if (div_done)
                begin
                    state_next = S_MOD_STEP;
                end
            end
            S_MOD_STEP:
            begin
                if (div_done)
                begin
                    state_next = S_MOD_STRIDE;
                end
            end
            S_MOD_STRIDE:
            begin
                if (div_done)
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_PROBE_RD:
            begin
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (slot_free || last_probe)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = IDX_W'(pos_reg);
        ram_wdata    = {key_reg, 1'b1};
        ram_raddr    = IDX_W'(pos_reg);
        div_start    = 1'b0;
        div_dividend = DVD_W'(key_reg);
        div_divisor  = eff_size;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                s_tready     = 1'b1;
                div_start    = s_tvalid && !table_full;
                div_dividend = DVD_W'(s_tdata[KEY_BITS-1:0]);
            end
            S_MOD_POS:
            begin
                // key mod prime next
                div_start   = div_done;
                div_divisor = eff_prime;
            end
            S_MOD_STEP:
            begin
                // step mod size gives the stride
                div_start    = div_done;
                div_dividend = DVD_W'(step_val);
            end
            S_PROBE_CHK:
            begin
                ram_we = slot_free;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            slot_limit_reg <= RESET_SLOT_LIMIT;
            step_prime_reg <= RESET_STEP_PRIME;
            count_reg      <= '0;
            clr_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SLOT_LIMIT: slot_limit_reg <= cfg_wdata;
                    REG_STEP_PRIME: step_prime_reg <= cfg_wdata;
                    default:        slot_limit_reg <= slot_limit_reg;
                endcase
            end
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (state_reg == S_PROBE_CHK && slot_free)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                key_reg        <= s_tdata[KEY_BITS-1:0];
                res_status_reg <= STAT_FULL;
                res_slot_reg   <= '0;
            end
            S_MOD_POS:
            begin
                if (div_done)
                begin
                    pos_reg <= div_rem;
                end
            end
            S_MOD_STRIDE:
            begin
                stride_reg <= div_rem;
                probe_reg  <= '0;
            end
            S_PROBE_CHK:
            begin
                if (slot_free)
                begin
                    res_status_reg <= STAT_INSERTED;
                    res_slot_reg   <= pos_reg;
                end
                else if (last_probe)
                begin
                    res_status_reg <= STAT_NO_SLOT;
                    res_slot_reg   <= '0;
                end
                else
                begin
                    pos_reg   <= pos_adv;
                    probe_reg <= probe_reg + CFG_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {{PAD_W{1'b0}}, COUNT_W'(count_reg),
                                    SLOT_W'(res_slot_reg), res_status_reg};
                end
            end
            default:
            begin
                key_reg <= key_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    dht_mod_unit #(
        .DVD_W (DVD_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    dht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // stored count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TABLE_DEPTH)
        else $error("stored count above depth");

    // probe position and stride stay inside the table in use
    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE_CHK) |-> (pos_reg < eff_size && stride_reg < eff_size))
        else $error("probe outside table");

    // an accepted word always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word not started");

    // a free slot found bumps the count by exactly one
    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE_CHK && slot_free) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert not counted");

endmodule
